// ----- hw/rtl/sacs_pkg.sv -----
// Shared types and constants for the SPI converter channel scanner.
// No dependencies; compiled first.
package sacs_pkg;

   localparam int DOUT_W          = 4;
   localparam int CHANNEL_W       = 3;
   localparam int BOARD_W         = 2;
   localparam int PHASE_W         = 5;
   localparam int BOARD_COUNT_W   = 3;
   localparam int USED_SENSORS_W  = 6;
   localparam int SAMPLE_INDEX_W  = 5;
   localparam int SAMPLE_VALUE_W  = 12;
   localparam int CSR_INDEX_W     = 1;
   localparam int CSR_DATA_W      = 6;

   // Command word: two start bits above the channel number, left aligned in a byte
   localparam logic [7:0] CMD_START_BITS = 8'h18;
   localparam logic [7:0] CMD_TOP_BIT    = 8'h80;
   localparam int         CMD_SLOTS      = 5;
   localparam int         IDLE_CLOCKS    = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_BOARD_COUNT  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_USED_SENSORS = 1'b1;

   localparam logic [BOARD_COUNT_W-1:0]  BOARD_COUNT_RESET  = 3'd2;
   localparam logic [USED_SENSORS_W-1:0] USED_SENSORS_RESET = 6'd10;

   typedef struct packed {
      logic [BOARD_COUNT_W-1:0]  board_count;
      logic [USED_SENSORS_W-1:0] used_sensors;
   } sacs_cfg_type;

   typedef struct packed {
      logic                      cs_level;
      logic                      din_level;
      logic                      clock_pulse;
      logic                      sample_valid;
      logic [SAMPLE_INDEX_W-1:0] sample_index;
      logic [SAMPLE_VALUE_W-1:0] sample_value;
      logic                      scan_done;
   } sacs_slot_type;

endpackage

// ----- hw/rtl/sacs_if.sv -----
// Valid/ready channel interfaces for the scanner's slot requests and slot results.
// Depends on sacs_pkg for field widths.
interface sacs_req_if import sacs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              start_req;
   logic [DOUT_W-1:0] dout_lines;

   modport source (output valid, output start_req, output dout_lines, input ready);
   modport sink   (input valid, input start_req, input dout_lines, output ready);
endinterface

interface sacs_rsp_if import sacs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      cs_level;
   logic                      din_level;
   logic                      clock_pulse;
   logic                      sample_valid;
   logic [SAMPLE_INDEX_W-1:0] sample_index;
   logic [SAMPLE_VALUE_W-1:0] sample_value;
   logic                      scan_done;

   modport source (output valid, output cs_level, output din_level, output clock_pulse,
                   output sample_valid, output sample_index, output sample_value,
                   output scan_done, input ready);
   modport sink   (input valid, input cs_level, input din_level, input clock_pulse,
                   input sample_valid, input sample_index, input sample_value,
                   input scan_done, output ready);
endinterface

// ----- hw/rtl/sacs_slot_engine.sv -----
// Scan sequencer: per-slot chip select, command bits, clocking and sample assembly.
// Depends on sacs_pkg.
module sacs_slot_engine import sacs_pkg::*; #(
   parameter int CHANNELS_PER_BOARD = 8,
   parameter int MAX_BOARDS         = 4,
   parameter int SAMPLE_BITS        = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              start_req,
   input  logic [DOUT_W-1:0] dout_lines,
   input  sacs_cfg_type      cfg,
   output sacs_slot_type     slot
);

   localparam int FIRST_SAMPLE_PHASE = 1 + CMD_SLOTS + IDLE_CLOCKS;
   localparam int LAST_PHASE         = FIRST_SAMPLE_PHASE + SAMPLE_BITS - 1;

   logic                   busy_ff,  busy_in;
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [CHANNEL_W-1:0]   channel_ff, channel_in;
   logic [BOARD_W-1:0]     board_ff, board_in;
   logic [SAMPLE_BITS-1:0] shift_ff, shift_in;
   logic                   held_din_ff, held_din_in;

   logic                   active;
   logic [7:0]             cmd_word;
   logic [7:0]             cmd_shifted;
   logic [BOARD_COUNT_W-1:0]  boards_in_use;
   logic [USED_SENSORS_W-1:0] global_index;
   logic [SAMPLE_BITS+SAMPLE_VALUE_W-1:0] value_ext;
   logic                   last_channel;
   logic                   last_board;

   always_comb begin
      if (cfg.board_count == '0) begin
         boards_in_use = BOARD_COUNT_W'(1);
      end else if (cfg.board_count > BOARD_COUNT_W'(MAX_BOARDS)) begin
         boards_in_use = BOARD_COUNT_W'(MAX_BOARDS);
      end else begin
         boards_in_use = cfg.board_count;
      end
   end

   assign cmd_word     = (CMD_START_BITS | 8'(channel_ff)) << 3;
   assign cmd_shifted  = cmd_word << (phase_ff - PHASE_W'(1));
   assign global_index = USED_SENSORS_W'(board_ff) * USED_SENSORS_W'(CHANNELS_PER_BOARD)
                       + USED_SENSORS_W'(channel_ff);
   assign last_channel = (channel_ff == CHANNEL_W'(CHANNELS_PER_BOARD - 1));
   assign last_board   = ((BOARD_COUNT_W'(board_ff) + BOARD_COUNT_W'(1)) >= boards_in_use);
   assign active       = busy_ff || start_req;

   always_comb begin
      busy_in     = busy_ff;
      phase_in    = phase_ff;
      channel_in  = channel_ff;
      board_in    = board_ff;
      shift_in    = shift_ff;
      held_din_in = held_din_ff;

      slot.cs_level     = 1'b1;
      slot.din_level    = held_din_ff;
      slot.clock_pulse  = 1'b0;
      slot.sample_valid = 1'b0;
      slot.sample_index = '0;
      slot.sample_value = '0;
      slot.scan_done    = 1'b0;
      value_ext         = '0;

      if (active) begin
         busy_in = 1'b1;
         if (phase_ff == '0) begin
            // released slot: drop data-in, clear the assembly register
            held_din_in    = 1'b0;
            slot.din_level = 1'b0;
            shift_in       = '0;
         end else if (phase_ff <= PHASE_W'(CMD_SLOTS)) begin
            slot.cs_level    = 1'b0;
            slot.clock_pulse = 1'b1;
            held_din_in      = |(cmd_shifted & CMD_TOP_BIT);
            slot.din_level   = held_din_in;
         end else if (phase_ff < PHASE_W'(FIRST_SAMPLE_PHASE)) begin
            slot.cs_level    = 1'b0;
            slot.clock_pulse = 1'b1;
         end else begin
            slot.cs_level    = 1'b0;
            slot.clock_pulse = 1'b1;
            shift_in         = {shift_ff[SAMPLE_BITS-2:0], dout_lines[board_ff]};
         end

         if (phase_ff >= PHASE_W'(LAST_PHASE)) begin
            value_ext = {{SAMPLE_VALUE_W{1'b0}}, shift_in};
            if (global_index < cfg.used_sensors) begin
               slot.sample_valid = 1'b1;
               slot.sample_index = global_index[SAMPLE_INDEX_W-1:0];
               slot.sample_value = value_ext[SAMPLE_VALUE_W-1:0];
            end
            phase_in = '0;
            if (last_channel) begin
               channel_in = '0;
               if (last_board) begin
                  board_in       = '0;
                  busy_in        = 1'b0;
                  slot.scan_done = 1'b1;
               end else begin
                  board_in = board_ff + BOARD_W'(1);
               end
            end else begin
               channel_in = channel_ff + CHANNEL_W'(1);
            end
         end else begin
            phase_in = phase_ff + PHASE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         phase_ff    <= '0;
         channel_ff  <= '0;
         board_ff    <= '0;
         shift_ff    <= '0;
         held_din_ff <= 1'b0;
      end else if (advance) begin
         busy_ff     <= busy_in;
         phase_ff    <= phase_in;
         channel_ff  <= channel_in;
         board_ff    <= board_in;
         shift_ff    <= shift_in;
         held_din_ff <= held_din_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_idle_counters_zero: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (phase_ff == '0 && channel_ff == '0 && board_ff == '0))
      else $error("scan counters not at rest while idle");

   a_phase_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_W'(LAST_PHASE))
      else $error("slot phase beyond last sample bit");

   a_done_ends_scan: assert property (@(posedge clock) disable iff (reset)
      (advance && slot.scan_done) |=> !busy_ff)
      else $error("scan still busy after done slot");

   a_sample_while_selected: assert property (@(posedge clock) disable iff (reset)
      slot.sample_valid |-> (!slot.cs_level && slot.clock_pulse && active))
      else $error("sample reported outside a clocked selected slot");
`endif

endmodule

// ----- hw/rtl/spi_adc_channel_scanner.sv -----
// Top level of the SPI converter channel scanner: slot pipeline and CSR bank.
// Depends on sacs_pkg, sacs_if and sacs_slot_engine.
//
// Usage: each transfer on req is one serial bit slot of the converter bus and
// carries the start request and the boards' data-out levels. For each slot
// exactly one transfer appears on rsp with chip select, data-in and clock
// levels for that slot, plus a finished sample and the end-of-scan flag
// when they occur. A start request while idle launches a sweep over every
// channel of every configured board (at least one, at most MAX_BOARDS);
// each channel takes 8 + SAMPLE_BITS slots (one released, five command,
// two idle, the sample bits). Each result passes the input register, then
// the result register, before it is offered on rsp. Throughput: one slot
// per cycle unless rsp stalls; the sequencer state is updated once per
// slot.
// Reset returns the sequencer to idle with data-in low and loads the
// default board count (2) and reported-sample limit (10).
// When rsp stalls, the result register holds and the input register
// fills; req.ready drops once both are occupied and rsp.ready is low.
// CSR writes (csr_we, csr_index, csr_wdata) take effect at once; the user must
// make them only while no slot is in flight; the block has no check for it.
module spi_adc_channel_scanner import sacs_pkg::*; #(
   parameter int CHANNELS_PER_BOARD = 8,
   parameter int MAX_BOARDS         = 4,
   parameter int SAMPLE_BITS        = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   sacs_req_if.sink               req,
   sacs_rsp_if.source             rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic              in_valid_ff;
   logic              in_start_ff;
   logic [DOUT_W-1:0] in_dout_ff;
   logic              out_valid_ff;
   sacs_slot_type     out_ff;
   sacs_slot_type     slot;
   sacs_cfg_type      cfg_ff;
   logic              advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   // hold payload until the slot moves on
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_start_ff <= req.start_req;
         in_dout_ff  <= req.dout_lines;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.board_count  <= BOARD_COUNT_RESET;
         cfg_ff.used_sensors <= USED_SENSORS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BOARD_COUNT: begin
               cfg_ff.board_count <= csr_wdata[BOARD_COUNT_W-1:0];
            end
            CSR_USED_SENSORS: begin
               cfg_ff.used_sensors <= csr_wdata[USED_SENSORS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   sacs_slot_engine #(
      .CHANNELS_PER_BOARD (CHANNELS_PER_BOARD),
      .MAX_BOARDS         (MAX_BOARDS),
      .SAMPLE_BITS        (SAMPLE_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .start_req  (in_start_ff),
      .dout_lines (in_dout_ff),
      .cfg        (cfg_ff),
      .slot       (slot)
   );

   assign rsp.valid        = out_valid_ff;
   assign rsp.cs_level     = out_ff.cs_level;
   assign rsp.din_level    = out_ff.din_level;
   assign rsp.clock_pulse  = out_ff.clock_pulse;
   assign rsp.sample_valid = out_ff.sample_valid;
   assign rsp.sample_index = out_ff.sample_index;
   assign rsp.sample_value = out_ff.sample_value;
   assign rsp.scan_done    = out_ff.scan_done;

endmodule
